[rtl/core/assert_macros.svh]
// Assertion macros used by the top level RTL file of the sorted key map.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge of clk while rst_n is high.
`define ASSERT_AT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition is never true at a rising edge of clk while rst_n is high.
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[rtl/core/skmu_pkg.sv]
// Types and constants shared by the sorted key map modules.
package skmu_pkg;

    localparam int unsigned KEY_W     = 64;
    localparam int unsigned DEST_W    = 64;
    localparam int unsigned KIND_W    = 16;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned COUNT_W   = 7;
    localparam int unsigned DEPTH_DEF = 64;

    localparam int unsigned S_TDATA_W = ((KEY_W + DEST_W + KIND_W + 7) / 8) * 8;
    localparam int unsigned M_TDATA_W = ((STATUS_W + COUNT_W + 7) / 8) * 8;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_KEY = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [DEST_W-1:0] dest;
        logic [KIND_W-1:0] kind;
    } entry_t;

    typedef struct packed {
        logic insert;
        logic update;
    } cell_cmd_t;

endpackage

[rtl/core/skmu_cell.sv]
// One table cell: holds an entry, compares it with the request and shifts or loads.
module skmu_cell (
    input  logic                clk,
    input  skmu_pkg::cell_cmd_t cmd,
    input  skmu_pkg::entry_t    req,
    input  logic                occupied,
    input  logic                left_ge,
    input  skmu_pkg::entry_t    left_entry,
    output logic                ge,
    output logic                eq,
    output skmu_pkg::entry_t    entry
);
    import skmu_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // An empty cell counts as holding a key above every request key.
    always_comb
    begin
        ge = !occupied || (entry_reg.key >= req.key);
        eq = occupied && (entry_reg.key == req.key);
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.insert)
        begin
            if (ge && left_ge)
            begin
                entry_next = left_entry;
            end
            else if (ge)
            begin
                entry_next = req;
            end
        end
        else if (cmd.update && eq)
        begin
            entry_next.dest = req.dest;
            entry_next.kind = req.kind;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

[rtl/core/sorted_key_map_upsert_top.sv]
// Top level of the sorted key map with insert-or-update.
//
// The block keeps up to TABLE_DEPTH entries sorted by ascending nonzero key in a
// row of cells. Each request on the s_ channel carries a key, a destination and
// a kind. A present key has its destination and kind overwritten; a new key is
// inserted at its sorted place while all cells above it take their lower
// neighbor's entry in the same cycle. A zero key is rejected, and a new key
// arriving at a full table is refused with the full status.
// Every request yields exactly one response on the m_ channel: the status and
// the entry count after the request.
// A request is registered on acceptance; once the output register can take a
// response (it is empty or m_tready is high), every cell compares its key with
// it in parallel, the table is updated and the response is loaded into the
// output register. A new request is taken only after the held one has been
// applied, since the input register holds one request while the cells compare.
// When m_tready is low the response waits in the output register and the
// pending request stays in the input register; s_tready stays low meanwhile.
// Reset empties the table at once by clearing the entry count.
`include "assert_macros.svh"

module sorted_key_map_upsert_top #(
    parameter int unsigned TABLE_DEPTH = skmu_pkg::DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // Fields from bit 0: key (64), destination (64), entry_kind (16).
    input  logic [skmu_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // Fields from bit 0: status (2), entry_count (7), zero padding.
    output logic [skmu_pkg::M_TDATA_W-1:0] m_tdata
);
    import skmu_pkg::*;

    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned PAD_W = M_TDATA_W - STATUS_W - COUNT_W;

    logic               busy_reg;
    logic               busy_next;
    entry_t             req_reg;
    entry_t             req_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    status_t            status_reg;
    status_t            status_next;
    logic [COUNT_W-1:0] out_count_reg;
    logic [COUNT_W-1:0] out_count_next;

    logic               accept;
    logic               apply;
    logic               found;
    logic               full;
    logic [CNT_W-1:0]   item_count;
    cell_cmd_t          cmd;

    logic [TABLE_DEPTH-1:0] ge_vec;
    logic [TABLE_DEPTH-1:0] eq_vec;
    logic [TABLE_DEPTH-1:0] occ_vec;
    entry_t                 entry_arr [TABLE_DEPTH];

    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && !busy_reg;
    assign apply    = busy_reg && (!out_valid_reg || m_tready);
    assign found    = |eq_vec;
    assign full     = (count_reg == CNT_W'(TABLE_DEPTH));

    always_comb
    begin
        req_next = req_reg;
        if (accept)
        begin
            req_next.key  = s_tdata[KEY_W-1:0];
            req_next.dest = s_tdata[KEY_W+DEST_W-1:KEY_W];
            req_next.kind = s_tdata[KEY_W+DEST_W+KIND_W-1:KEY_W+DEST_W];
        end
    end

    always_comb
    begin
        cmd         = '0;
        status_next = ST_OK;
        item_count  = count_reg;
        if (req_reg.key == '0)
        begin
            status_next = ST_ZERO_KEY;
        end
        else if (found)
        begin
            cmd.update = apply;
        end
        else if (full)
        begin
            status_next = ST_FULL;
        end
        else
        begin
            cmd.insert = apply;
            item_count = count_reg + 1'b1;
        end
    end

    always_comb
    begin
        count_next     = apply ? item_count : count_reg;
        out_count_next = apply ? COUNT_W'(item_count) : out_count_reg;
        busy_next      = accept ? 1'b1 : (apply ? 1'b0 : busy_reg);
        out_valid_next = apply ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        out_count_reg <= out_count_next;
        if (apply)
        begin
            status_reg <= status_next;
        end
    end

    genvar i;
    generate
        for (i = 0; i < TABLE_DEPTH; i++)
        begin : g_cell
            assign occ_vec[i] = (CNT_W'(i) < count_reg);
            if (i == 0)
            begin : g_first
                skmu_cell u_cell (
                    .clk        (clk),
                    .cmd        (cmd),
                    .req        (req_reg),
                    .occupied   (occ_vec[i]),
                    .left_ge    (1'b0),
                    .left_entry (req_reg),
                    .ge         (ge_vec[i]),
                    .eq         (eq_vec[i]),
                    .entry      (entry_arr[i])
                );
            end
            else
            begin : g_next
                skmu_cell u_cell (
                    .clk        (clk),
                    .cmd        (cmd),
                    .req        (req_reg),
                    .occupied   (occ_vec[i]),
                    .left_ge    (ge_vec[i-1]),
                    .left_entry (entry_arr[i-1]),
                    .ge         (ge_vec[i]),
                    .eq         (eq_vec[i]),
                    .entry      (entry_arr[i])
                );
            end
        end
    endgenerate

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_count_reg, status_reg};

    `ASSERT_AT_CLK(a_count_bound, count_reg <= CNT_W'(TABLE_DEPTH), "entry count too high")
    `ASSERT_AT_CLK(a_single_match, $onehot0(eq_vec), "key matched in more than one cell")
    `ASSERT_NEVER(a_cmd_both, cmd.insert && cmd.update, "insert and update in the same cycle")
    `ASSERT_AT_CLK(a_insert_count, cmd.insert |=> count_reg == $past(item_count), "count stuck")
    `ASSERT_AT_CLK(a_full_status, (apply && status_next == ST_FULL) |-> full, "early full")

endmodule

[tb/sv/tb_sorted_key_map_upsert_top.sv]
// Self-checking testbench for the sorted key map with insert-or-update.
`timescale 1ns / 1ps

module tb_sorted_key_map_upsert_top;
    import skmu_pkg::*;

    localparam int unsigned TABLE_DEPTH  = DEPTH_DEF;
    localparam int unsigned RANDOM_ITEMS = 1540;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    class sorted_map_shadow;
        logic [KEY_W-1:0]   keys[TABLE_DEPTH];
        logic [DEST_W-1:0]  dests[TABLE_DEPTH];
        logic [KIND_W-1:0]  kinds[TABLE_DEPTH];
        int unsigned        fill;
        status_t            pending_status[$];
        logic [COUNT_W-1:0] pending_count[$];
        int unsigned        mismatches;

        function new();
            fill       = 0;
            mismatches = 0;
        endfunction

        function int unsigned pending();
            return pending_status.size();
        endfunction

        function void apply_upsert(logic [KEY_W-1:0] key, logic [DEST_W-1:0] dest,
                                   logic [KIND_W-1:0] kind);
            status_t     st;
            int unsigned slot;
            st = ST_OK;
            if (key == '0)
            begin
                st = ST_ZERO_KEY;
            end
            else
            begin
                slot = 0;
                while (slot < fill && keys[slot] < key)
                begin
                    slot++;
                end
                if (slot < fill && keys[slot] == key)
                begin
                    dests[slot] = dest;
                    kinds[slot] = kind;
                end
                else if (fill >= TABLE_DEPTH)
                begin
                    st = ST_FULL;
                end
                else
                begin
                    for (int j = fill; j > slot; j--)
                    begin
                        keys[j]  = keys[j-1];
                        dests[j] = dests[j-1];
                        kinds[j] = kinds[j-1];
                    end
                    keys[slot]  = key;
                    dests[slot] = dest;
                    kinds[slot] = kind;
                    fill++;
                end
            end
            pending_status.push_back(st);
            pending_count.push_back(COUNT_W'(fill));
        endfunction

        function void check_response(logic [M_TDATA_W-1:0] word);
            status_t            want_status;
            logic [COUNT_W-1:0] want_count;
            if (pending_status.size() == 0)
            begin
                $display("%0t: response with none expected, actual status %0d count %0d",
                         $time, word[STATUS_W-1:0], word[STATUS_W +: COUNT_W]);
                mismatches++;
            end
            else
            begin
                want_status = pending_status.pop_front();
                want_count  = pending_count.pop_front();
                if (word[STATUS_W-1:0] !== want_status)
                begin
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, want_status, word[STATUS_W-1:0]);
                    mismatches++;
                end
                if (word[STATUS_W +: COUNT_W] !== want_count)
                begin
                    $display("%0t: entry count mismatch, expected %0d actual %0d",
                             $time, want_count, word[STATUS_W +: COUNT_W]);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    sorted_map_shadow     shadow = new();
    logic [KEY_W-1:0]     issued_keys[$];
    int unsigned          cycle_count = 0;

    sorted_key_map_upsert_top #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever
        begin
            #1 clk = ~clk;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // The receiver holds off once for a long stretch so that the block backs up.
    initial
    begin
        int unsigned rx_cycle;
        rx_cycle = 0;
        forever
        begin
            @(posedge clk);
            rx_cycle++;
            if (m_tvalid && m_tready)
            begin
                shadow.check_response(m_tdata);
            end
            if (!rst_n || (rx_cycle >= 600 && rx_cycle < 900))
            begin
                m_tready <= 1'b0;
            end
            else if (rx_cycle >= 2500 && rx_cycle < 3500)
            begin
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= 23);
            end
        end
    end

    task automatic send_request(input logic [KEY_W-1:0] key, input logic [DEST_W-1:0] dest,
                                input logic [KIND_W-1:0] kind, input bit allow_gap);
        if (allow_gap && $urandom_range(0, 99) < 23)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {kind, dest, key};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        shadow.apply_upsert(key, dest, kind);
        if (key != '0)
        begin
            issued_keys.push_back(key);
        end
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        int unsigned roll;
        int unsigned idx;
        roll = $urandom_range(0, 99);
        idx  = (issued_keys.size() > 0) ? $urandom_range(0, issued_keys.size() - 1) : 0;
        if (roll < 10 || issued_keys.size() == 0)
        begin
            return (roll < 10) ? '0 : {$urandom, $urandom};
        end
        else if (roll < 75)
        begin
            return issued_keys[idx];
        end
        else if (roll < 80)
        begin
            return issued_keys[idx] + 1'b1;
        end
        else if (roll < 85)
        begin
            return issued_keys[idx] - 1'b1;
        end
        else if (roll < 88)
        begin
            return KEY_W'($urandom_range(1, 255));
        end
        return {$urandom, $urandom};
    endfunction

    initial
    begin
        logic [KEY_W-1:0] ones;
        ones = '1;
        @(posedge rst_n);
        @(posedge clk);

        // Directed: zero keys, extreme keys and values, inserts at both ends, updates.
        send_request('0, ones, '1, 1'b0);
        send_request(ones, '0, '0, 1'b0);
        send_request(64'd1, ones, '1, 1'b0);
        send_request(64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555, 16'haaaa, 1'b0);
        send_request(ones, 64'haaaa_aaaa_aaaa_aaaa, 16'h5555, 1'b0);
        send_request(64'd1, '0, '0, 1'b0);
        send_request(64'd2, 64'h0123_4567_89ab_cdef, 16'h0001, 1'b1);
        send_request(ones - 1'b1, 64'hfedc_ba98_7654_3210, 16'h8000, 1'b1);
        send_request('0, '0, '0, 1'b1);
        send_request(64'h7fff_ffff_ffff_ffff, ones, 16'h7fff, 1'b1);
        send_request(64'd2, 64'd7, 16'hffff, 1'b1);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 350)
            begin
                s_tvalid <= 1'b0;
                do
                begin
                    @(posedge clk);
                end
                while (shadow.pending() != 0);
            end
            send_request(pick_key(), {$urandom, $urandom}, KIND_W'($urandom),
                         !(n >= 800 && n < 1000));
        end
        s_tvalid <= 1'b0;

        while (shadow.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (shadow.mismatches == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[sorted_key_map_upsert_top.f]
+incdir+rtl/core
rtl/core/skmu_pkg.sv
rtl/core/skmu_cell.sv
rtl/core/sorted_key_map_upsert_top.sv
tb/sv/tb_sorted_key_map_upsert_top.sv
